[hdl/ffsa_pkg.sv]
package ffsa_pkg;

    localparam int unsigned STATUS_W = 3;
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned STRIDE_W = 14;
    localparam int unsigned UNITS_W  = 21;
    localparam int unsigned START_W  = 20;
    localparam int unsigned CFG_W    = 32;
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [UNITS_W-1:0] POOL_MAX_UNITS = 21'd1048576;
    localparam int unsigned PALETTE_BYTES = 256 * 4;
    localparam logic [7:0] BPP_PALETTE = 8'd8;
    localparam logic [7:0] BPP_TRUE    = 8'd32;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_UNITS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHYS_BASE  = 1'd1;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DEPTH    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic        req_type;
        logic [15:0] owner_tag;
        logic [12:0] line_stride_bytes;
        logic [11:0] line_count;
        logic [7:0]  bits_per_pixel;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   surf_addr;
        logic [STRIDE_W-1:0] aligned_stride;
    } t_rsp;

endpackage

[hdl/ffsa_ram.sv]
module ffsa_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/ffsa_size.sv]
module ffsa_size
    import ffsa_pkg::*;
#(
    parameter int unsigned ALIGN_SHIFT = 6
) (
    input  logic                i_clk,
    input  t_req                i_req,
    output logic [STRIDE_W-1:0] o_stride,
    output logic [UNITS_W:0]    o_need,
    output logic                o_zero,
    output logic                o_bad_depth
);

    localparam int unsigned BYTES_W = 40;
    localparam logic [BYTES_W-1:0] UNIT_MASK = BYTES_W'((64'd1 << ALIGN_SHIFT) - 64'd1);

    logic [BYTES_W-1:0] stride_w;
    logic [BYTES_W-1:0] r_stride;
    logic [11:0]        r_lines;
    logic [7:0]         r_bpp;
    logic [BYTES_W-1:0] size;
    logic [BYTES_W-1:0] need_bytes;

    assign stride_w = (BYTES_W'(i_req.line_stride_bytes) + UNIT_MASK) & ~UNIT_MASK;

    always_ff @(posedge i_clk) begin
        r_stride <= stride_w;
        r_lines  <= i_req.line_count;
        r_bpp    <= i_req.bits_per_pixel;
    end

    always_comb begin
        size = BYTES_W'(r_stride[26:0] * r_lines);
        need_bytes = size + ((r_bpp == BPP_PALETTE) ? BYTES_W'(PALETTE_BYTES) : '0);
        need_bytes = (need_bytes + UNIT_MASK) >> ALIGN_SHIFT;
    end

    assign o_stride    = STRIDE_W'(r_stride);
    assign o_need      = (need_bytes > BYTES_W'(2 ** UNITS_W)) ? (UNITS_W+1)'(2 ** UNITS_W)
                                                             : (UNITS_W+1)'(need_bytes);
    assign o_zero      = (size == '0);
    assign o_bad_depth = (r_bpp != BPP_PALETTE) && (r_bpp != BPP_TRUE);

endmodule

[hdl/first_fit_surface_allocator.sv]
// Usage: a first-fit allocator of pool units kept as an address-ordered block table.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data while the
// block is idle. Index 0 sets the pool size in units and re-forms the table as one
// free block; index 1 sets the physical base address.
// A request is taken when i_start is high and o_busy is low. i_req carries the
// request type, owner and surface geometry. Exactly one result follows per request:
// o_rsp is shown for one cycle with o_done high; the receiver cannot stall it.
// Each request scans the table one entry at a time through the read port of
// the table memory, then shifts entries one at a time for a split or merge.
// One request is in work at a time.
// Reset empties the pool: one free block of zero units, base address zero.
module first_fit_surface_allocator
    import ffsa_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS  = 64,
    parameter int unsigned ALIGN_SHIFT = 6,
    parameter int unsigned OWNER_BITS  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  t_req                 i_req,
    output logic                 o_done,
    output t_rsp                 o_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int unsigned IW = $clog2(MAX_BLOCKS);
    localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned EW = START_W + UNITS_W + OWNER_BITS + 1;

    typedef struct packed {
        logic [START_W-1:0]    start;
        logic [UNITS_W-1:0]    units;
        logic [OWNER_BITS-1:0] owner;
        logic                  used;
    } t_ent;

    typedef enum logic [3:0] {
        S_IDLE, S_SIZE, S_RD, S_SCAN, S_SHUP_RD, S_SHUP_WR, S_SPLIT,
        S_MERGE_RD, S_MERGE_CHK, S_SHDN_RD, S_SHDN_WR, S_RESP
    } t_state;

    t_state             r_state;
    logic [CW-1:0]      r_count;
    logic [IW-1:0]      r_idx;
    logic [IW-1:0]      r_k;
    logic [IW-1:0]      r_hit;
    logic               r_op_free;
    logic [OWNER_BITS-1:0] r_owner;
    logic [ADDR_W-1:0]  r_base;
    logic [STRIDE_W-1:0] r_stride;
    logic [UNITS_W:0]   r_need;
    t_ent               r_cur;
    t_ent               r_prev;
    logic               r_have_prev;
    logic               r_merge_phase;
    logic               r_done;
    t_rsp               r_rsp;
    logic               r_wr;
    logic [IW-1:0]      r_waddr;
    t_ent               r_wdata;

    logic [IW-1:0]      rd_addr;
    logic [EW-1:0]      rd_raw;
    t_ent               rd_ent;
    logic [STRIDE_W-1:0] sz_stride;
    logic [UNITS_W:0]   sz_need;
    logic               sz_zero;
    logic               sz_bad;
    logic [UNITS_W-1:0] cfg_units;
    logic [UNITS_W-1:0] remain;

    ffsa_size #(.ALIGN_SHIFT(ALIGN_SHIFT)) u_size (
        .i_clk       (i_clk),
        .i_req       (i_req),
        .o_stride    (sz_stride),
        .o_need      (sz_need),
        .o_zero      (sz_zero),
        .o_bad_depth (sz_bad)
    );

    ffsa_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_table (
        .i_clk   (i_clk),
        .i_we    (r_wr),
        .i_waddr (r_waddr),
        .i_wdata (r_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rd_raw)
    );

    assign rd_ent    = t_ent'(rd_raw);
    assign cfg_units = (i_cfg_data[UNITS_W-1:0] > POOL_MAX_UNITS) ? POOL_MAX_UNITS
                                                                  : i_cfg_data[UNITS_W-1:0];
    assign remain    = rd_ent.units - UNITS_W'(r_need);

    always_comb begin
        rd_addr = r_idx;
        unique case (r_state)
            S_SHUP_RD:  rd_addr = r_k;
            S_SHDN_RD:  rd_addr = r_k + IW'(1);
            S_MERGE_RD: rd_addr = r_hit + IW'(1);
            default:    rd_addr = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_wr <= 1'b0;
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= CW'(1);
            r_base  <= '0;
            r_wr    <= 1'b1;
            r_waddr <= '0;
            r_wdata <= '0;
        end else begin
            if (i_cfg_we && r_state == S_IDLE) begin
                if (i_cfg_idx == CFG_POOL_UNITS) begin
                    r_count <= CW'(1);
                    r_wr    <= 1'b1;
                    r_waddr <= '0;
                    r_wdata <= '{start: '0, units: cfg_units, owner: '0, used: 1'b0};
                end else begin
                    r_base <= i_cfg_data;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_op_free <= i_req.req_type;
                        r_owner   <= OWNER_BITS'(i_req.owner_tag);
                        r_idx     <= '0;
                        r_have_prev <= 1'b0;
                        r_rsp     <= '0;
                        r_state   <= S_SIZE;
                    end
                end
                S_SIZE: begin
                    r_stride <= sz_stride;
                    r_need   <= sz_need;
                    if (!r_op_free && sz_zero) begin
                        r_rsp.status <= ST_ZERO;
                        r_state <= S_RESP;
                    end else if (!r_op_free && sz_bad) begin
                        r_rsp.status <= ST_DEPTH;
                        r_state <= S_RESP;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (!r_op_free && !rd_ent.used &&
                        (UNITS_W+1)'(rd_ent.units) >= r_need) begin
                        r_cur <= rd_ent;
                        r_hit <= r_idx;
                        if (remain != '0) begin
                            if (r_count >= CW'(MAX_BLOCKS)) begin
                                r_rsp.status <= ST_FULL;
                                r_state <= S_RESP;
                            end else begin
                                r_k <= IW'(r_count - CW'(1));
                                r_state <= S_SHUP_RD;
                            end
                        end else begin
                            r_wr    <= 1'b1;
                            r_waddr <= r_idx;
                            r_wdata <= '{start: rd_ent.start, units: rd_ent.units,
                                         owner: r_owner, used: 1'b1};
                            r_rsp   <= '{status: ST_OK,
                                         surf_addr: r_base + ADDR_W'(64'(rd_ent.start) << ALIGN_SHIFT),
                                         aligned_stride: r_stride};
                            r_state <= S_RESP;
                        end
                    end else if (r_op_free && rd_ent.used && rd_ent.owner == r_owner) begin
                        if (r_have_prev && !r_prev.used) begin
                            r_merge_phase <= 1'b0;
                            r_wr    <= 1'b1;
                            r_waddr <= r_idx - IW'(1);
                            r_wdata <= '{start: r_prev.start,
                                         units: r_prev.units + rd_ent.units,
                                         owner: r_prev.owner, used: 1'b0};
                            r_cur   <= '{start: r_prev.start,
                                         units: r_prev.units + rd_ent.units,
                                         owner: r_prev.owner, used: 1'b0};
                            r_hit   <= r_idx - IW'(1);
                            r_k     <= r_idx;
                            r_state <= S_SHDN_RD;
                        end else begin
                            r_hit   <= r_idx;
                            r_wr    <= 1'b1;
                            r_waddr <= r_idx;
                            r_wdata <= '{start: rd_ent.start, units: rd_ent.units,
                                         owner: '0, used: 1'b0};
                            r_cur   <= '{start: rd_ent.start, units: rd_ent.units,
                                         owner: '0, used: 1'b0};
                            r_merge_phase <= 1'b1;
                            r_state <= S_MERGE_RD;
                        end
                    end else if (CW'(r_idx) + CW'(1) >= r_count) begin
                        if (!r_op_free) begin
                            r_rsp.status <= ST_NO_SPACE;
                        end
                        r_state <= S_RESP;
                    end else begin
                        r_prev <= rd_ent;
                        r_have_prev <= 1'b1;
                        r_idx <= r_idx + IW'(1);
                        r_state <= S_RD;
                    end
                end
                S_SHUP_RD: begin
                    if (r_k == r_hit) begin
                        r_state <= S_SPLIT;
                    end else begin
                        r_state <= S_SHUP_WR;
                    end
                end
                S_SHUP_WR: begin
                    r_wr    <= 1'b1;
                    r_waddr <= r_k + IW'(1);
                    r_wdata <= rd_ent;
                    r_k     <= r_k - IW'(1);
                    r_state <= S_SHUP_RD;
                end
                S_SPLIT: begin
                    r_wr    <= 1'b1;
                    r_waddr <= r_hit + IW'(1);
                    r_wdata <= '{start: r_cur.start + START_W'(r_cur.units - UNITS_W'(r_need)),
                                 units: UNITS_W'(r_need), owner: r_owner, used: 1'b1};
                    r_idx   <= r_hit;
                    r_count <= r_count + CW'(1);
                    r_rsp   <= '{status: ST_OK,
                                 surf_addr: r_base + ADDR_W'(64'(r_cur.start +
                                     START_W'(r_cur.units - UNITS_W'(r_need))) << ALIGN_SHIFT),
                                 aligned_stride: r_stride};
                    r_state <= S_MERGE_CHK;
                end
                S_MERGE_RD: begin
                    if (CW'(r_hit) + CW'(1) >= r_count) begin
                        r_state <= S_RESP;
                    end else begin
                        r_idx   <= r_hit + IW'(1);
                        r_state <= S_MERGE_CHK;
                    end
                end
                S_MERGE_CHK: begin
                    if (r_op_free && r_merge_phase) begin
                        if (!rd_ent.used) begin
                            r_wr    <= 1'b1;
                            r_waddr <= r_hit;
                            r_wdata <= '{start: r_cur.start,
                                         units: r_cur.units + rd_ent.units,
                                         owner: r_cur.owner, used: 1'b0};
                            r_merge_phase <= 1'b0;
                            r_k     <= r_hit + IW'(1);
                            r_state <= S_SHDN_RD;
                        end else begin
                            r_state <= S_RESP;
                        end
                    end else if (r_op_free) begin
                        r_state <= S_MERGE_CHK;
                        r_merge_phase <= 1'b1;
                    end else begin
                        r_wr    <= 1'b1;
                        r_waddr <= r_hit;
                        r_wdata <= '{start: r_cur.start,
                                     units: r_cur.units - UNITS_W'(r_need),
                                     owner: r_cur.owner, used: 1'b0};
                        r_state <= S_RESP;
                    end
                end
                S_SHDN_RD: begin
                    if (CW'(r_k) + CW'(1) >= r_count) begin
                        r_count <= r_count - CW'(1);
                        if (!r_merge_phase && r_state == S_SHDN_RD && r_have_prev) begin
                            r_have_prev <= 1'b0;
                            r_merge_phase <= 1'b1;
                            r_state <= S_MERGE_RD;
                        end else begin
                            r_state <= S_RESP;
                        end
                    end else begin
                        r_state <= S_SHDN_WR;
                    end
                end
                S_SHDN_WR: begin
                    r_wr    <= 1'b1;
                    r_waddr <= r_k;
                    r_wdata <= rd_ent;
                    r_k     <= r_k + IW'(1);
                    r_state <= S_SHDN_RD;
                end
                S_RESP: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

[hdl/ffsa_checker.sv]
module ffsa_checker
    import ffsa_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_done,
    input t_rsp o_rsp
);

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_busy) else $error("start not taken");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy) else $error("done while busy");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_rsp.status <= ST_FULL) else $error("bad status");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_rsp.status != ST_OK |-> o_rsp.surf_addr == '0)
        else $error("address on failure");

endmodule

bind first_fit_surface_allocator ffsa_checker u_ffsa_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);

[verif/tb.sv]
module tb;
    import ffsa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TABLE_DEPTH = 64;
    localparam int unsigned SETTLE_CYCLES = 300;

    typedef enum logic [1:0] {K_REQ, K_CFG, K_HOLD} t_kind;

    typedef struct {
        t_kind               kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        t_req                 req;
    } t_step;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_start;
    logic                 o_busy;
    t_req                 i_req;
    logic                 o_done;
    t_rsp                 o_rsp;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    t_step pending_steps[$];
    t_rsp  expected_rsps[$];
    int    error_count = 0;
    int    gap_left = 0;
    int    settle_count = 0;
    bit    cfg_fire;

    int unsigned   model_pool_units;
    logic [31:0]   model_base;
    int unsigned   blk_start[TABLE_DEPTH];
    int unsigned   blk_len[TABLE_DEPTH];
    logic [15:0]   blk_tag[TABLE_DEPTH];
    bit            blk_taken[TABLE_DEPTH];
    int unsigned   blk_n;

    first_fit_surface_allocator u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .o_busy    (o_busy),
        .i_req     (i_req),
        .o_done    (o_done),
        .o_rsp     (o_rsp),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic void table_clear();
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            blk_start[k] = 0;
            blk_len[k]   = 0;
            blk_tag[k]   = '0;
            blk_taken[k] = 0;
        end
        blk_len[0] = model_pool_units;
        blk_n = 1;
    endfunction

    function automatic void table_drop(int unsigned pos);
        for (int unsigned k = pos; k + 1 < blk_n; k++) begin
            blk_start[k] = blk_start[k+1];
            blk_len[k]   = blk_len[k+1];
            blk_tag[k]   = blk_tag[k+1];
            blk_taken[k] = blk_taken[k+1];
        end
        blk_n--;
    endfunction

    function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        int unsigned v;
        v = data & 32'h1F_FFFF;
        if (idx == CFG_POOL_UNITS) begin
            model_pool_units = (v > POOL_MAX_UNITS) ? POOL_MAX_UNITS : v;
            table_clear();
        end else begin
            model_base = data;
        end
    endfunction

    function automatic t_rsp allocate_surface(t_req r);
        t_rsp        rsp;
        longint unsigned stride;
        longint unsigned bytes;
        longint unsigned need;
        int unsigned remain;
        int unsigned i;
        rsp = '0;
        stride = (longint'(r.line_stride_bytes) + 63) & ~64'd63;
        bytes  = stride * r.line_count;
        if (bytes == 0) begin
            rsp.status = ST_ZERO;
            return rsp;
        end
        if (r.bits_per_pixel == BPP_PALETTE) bytes += PALETTE_BYTES;
        else if (r.bits_per_pixel != BPP_TRUE) begin
            rsp.status = ST_DEPTH;
            return rsp;
        end
        need = (bytes + 63) >> 6;
        for (i = 0; i < blk_n; i++) begin
            if (!blk_taken[i] && blk_len[i] >= need) begin
                remain = blk_len[i] - int'(need);
                if (remain != 0) begin
                    if (blk_n >= TABLE_DEPTH) begin
                        rsp.status = ST_FULL;
                        return rsp;
                    end
                    for (int unsigned k = blk_n; k > i; k--) begin
                        blk_start[k] = blk_start[k-1];
                        blk_len[k]   = blk_len[k-1];
                        blk_tag[k]   = blk_tag[k-1];
                        blk_taken[k] = blk_taken[k-1];
                    end
                    blk_n++;
                    blk_len[i] = remain;
                    i++;
                    blk_start[i] = blk_start[i-1] + remain;
                    blk_len[i]   = int'(need);
                end
                blk_taken[i] = 1;
                blk_tag[i]   = r.owner_tag;
                rsp.status = ST_OK;
                rsp.surf_addr = model_base + (blk_start[i] << 6);
                rsp.aligned_stride = stride[13:0];
                return rsp;
            end
        end
        rsp.status = ST_NO_SPACE;
        return rsp;
    endfunction

    function automatic void release_surface(logic [15:0] tag);
        int unsigned cur;
        for (int unsigned i = 0; i < blk_n; i++) begin
            if (blk_taken[i] && blk_tag[i] == tag) begin
                blk_taken[i] = 0;
                blk_tag[i]   = '0;
                cur = i;
                if (i > 0 && !blk_taken[i-1]) begin
                    blk_len[i-1] += blk_len[i];
                    table_drop(i);
                    cur = i - 1;
                end
                if (cur + 1 < blk_n && !blk_taken[cur+1]) begin
                    blk_len[cur] += blk_len[cur+1];
                    table_drop(cur + 1);
                end
                return;
            end
        end
    endfunction

    function automatic t_rsp predict_rsp(t_req r);
        t_rsp rsp;
        rsp = '0;
        if (r.req_type == 1'b0) rsp = allocate_surface(r);
        else release_surface(r.owner_tag);
        return rsp;
    endfunction

    // Driver: requests leave the queue in order; configuration writes and holds
    // wait until the allocator has drained and stayed quiet for a while.
    always @(posedge i_clk) begin
        cfg_fire = 1'b0;
        if (i_rst_n !== 1'b1) begin
            i_start <= 1'b0;
        end else if (i_start) begin
            if (!o_busy) begin
                expected_rsps.insert(expected_rsps.size(), predict_rsp(i_req));
                if ($urandom_range(0, 3) == 0) gap_left = 0;
                else gap_left = $urandom_range(0, 5);
                if (gap_left == 0 && pending_steps.size() != 0
                        && pending_steps[0].kind == K_REQ) begin
                    i_req <= pending_steps[0].req;
                    void'(pending_steps.pop_front());
                end else begin
                    i_start <= 1'b0;
                end
            end
        end else if (gap_left > 0) begin
            gap_left--;
        end else if (pending_steps.size() != 0) begin
            if (pending_steps[0].kind == K_REQ) begin
                i_req <= pending_steps[0].req;
                i_start <= 1'b1;
                void'(pending_steps.pop_front());
            end else if (expected_rsps.size() != 0 || o_busy) begin
                settle_count = 0;
            end else if (settle_count < SETTLE_CYCLES) begin
                settle_count++;
            end else begin
                settle_count = 0;
                if (pending_steps[0].kind == K_CFG) begin
                    cfg_fire = 1'b1;
                    i_cfg_idx <= pending_steps[0].idx;
                    i_cfg_data <= pending_steps[0].data;
                    apply_cfg(pending_steps[0].idx, pending_steps[0].data);
                end
                void'(pending_steps.pop_front());
            end
        end
        i_cfg_we <= cfg_fire;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_rsps.size() == 0) begin
                $display("%0t: unexpected transfer, actual %p", $time, o_rsp);
                error_count++;
            end else begin
                if (o_rsp.status !== expected_rsps[0].status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             expected_rsps[0].status, o_rsp.status);
                    error_count++;
                end
                if (o_rsp.surf_addr !== expected_rsps[0].surf_addr) begin
                    $display("%0t: surf_addr expected %h actual %h", $time,
                             expected_rsps[0].surf_addr, o_rsp.surf_addr);
                    error_count++;
                end
                if (o_rsp.aligned_stride !== expected_rsps[0].aligned_stride) begin
                    $display("%0t: aligned_stride expected %0d actual %0d", $time,
                             expected_rsps[0].aligned_stride, o_rsp.aligned_stride);
                    error_count++;
                end
                void'(expected_rsps.pop_front());
            end
        end
    end

    function automatic void add_req(logic kind_free, logic [15:0] tag, logic [12:0] stride,
                                    logic [11:0] lines, logic [7:0] bpp);
        t_step s;
        s.kind = K_REQ;
        s.idx = '0;
        s.data = '0;
        s.req = '{kind_free, tag, stride, lines, bpp};
        pending_steps.insert(pending_steps.size(), s);
    endfunction

    function automatic void add_ctrl(t_kind kind, logic [CFG_IDX_W-1:0] idx,
                                     logic [CFG_W-1:0] data);
        t_step s;
        s.kind = kind;
        s.idx = idx;
        s.data = data;
        s.req = '0;
        pending_steps.insert(pending_steps.size(), s);
    endfunction

    function automatic void add_random_req();
        int unsigned pick;
        logic [12:0] stride;
        logic [11:0] lines;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            stride = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 8191))
                                                 : 13'($urandom_range(1, 600));
            lines = ($urandom_range(0, 19) == 0) ? 12'($urandom_range(0, 4095))
                                                 : 12'($urandom_range(1, 40));
            add_req(1'b0, ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15)),
                    stride, lines, $urandom_range(0, 1) ? BPP_PALETTE : BPP_TRUE);
        end else if (pick < 90) begin
            add_req(1'b1, 16'($urandom_range(0, 15)), 13'($urandom), 12'($urandom), 8'($urandom));
        end else begin
            add_req(1'($urandom), 16'($urandom), 13'($urandom), 12'($urandom), 8'($urandom));
        end
    endfunction

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_req = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        model_pool_units = 0;
        model_base = '0;
        table_clear();

        // Empty pool after reset.
        add_req(1'b0, 16'h0001, 13'd64, 12'd1, BPP_TRUE);
        add_ctrl(K_CFG, CFG_POOL_UNITS, 32'd1048576);
        add_ctrl(K_CFG, CFG_PHYS_BASE, 32'hFFFF_F000);
        add_req(1'b0, 16'h0002, 13'd0, 12'd5, BPP_TRUE);
        add_req(1'b0, 16'h0002, 13'd100, 12'd0, BPP_PALETTE);
        add_req(1'b0, 16'h0002, 13'd0, 12'd0, 8'd7);
        add_req(1'b0, 16'h0002, 13'd64, 12'd4, 8'd16);
        add_req(1'b0, 16'h0002, 13'd64, 12'd4, 8'hFF);
        add_req(1'b0, 16'hFFFF, 13'h1FFF, 12'hFFF, BPP_TRUE);
        add_req(1'b0, 16'h0003, 13'd1, 12'd1, BPP_PALETTE);
        add_req(1'b0, 16'hAAAA, 13'd128, 12'd3, BPP_TRUE);
        add_req(1'b0, 16'h5555, 13'd65, 12'd2, BPP_TRUE);
        add_req(1'b0, 16'hAAAA, 13'd128, 12'd3, BPP_PALETTE);
        add_req(1'b1, 16'h1234, 13'd0, 12'd0, 8'd0);
        add_req(1'b1, 16'hAAAA, 13'd0, 12'd0, 8'd0);
        add_req(1'b1, 16'h5555, 13'd0, 12'd0, 8'd0);
        add_req(1'b1, 16'hAAAA, 13'd0, 12'd0, 8'd0);
        add_req(1'b0, 16'h0004, 13'h1FFF, 12'hFFF, BPP_PALETTE);
        add_req(1'b0, 16'h0005, 13'h1FFF, 12'hFFF, BPP_TRUE);
        // Exact fit in a small pool.
        add_ctrl(K_CFG, CFG_POOL_UNITS, 32'd32);
        add_req(1'b0, 16'h0006, 13'd64, 12'd32, BPP_TRUE);
        add_req(1'b0, 16'h0007, 13'd64, 12'd1, BPP_TRUE);
        add_req(1'b1, 16'h0006, 13'd0, 12'd0, 8'd0);

        for (int p = 0; p < 5; p++) begin
            case (p)
                0: begin
                    add_ctrl(K_CFG, CFG_POOL_UNITS, 32'hFFFF_FFFF);
                    add_ctrl(K_CFG, CFG_PHYS_BASE, 32'hFFFF_FFFF);
                end
                1: begin
                    add_ctrl(K_CFG, CFG_POOL_UNITS, 32'd5000);
                    add_ctrl(K_CFG, CFG_PHYS_BASE, $urandom);
                end
                2: begin
                    add_ctrl(K_CFG, CFG_POOL_UNITS, 32'd1048576);
                    add_ctrl(K_CFG, CFG_PHYS_BASE, 32'd0);
                end
                3: begin
                    add_ctrl(K_CFG, CFG_POOL_UNITS, $urandom);
                    add_ctrl(K_CFG, CFG_PHYS_BASE, $urandom);
                end
                default: begin
                    add_ctrl(K_CFG, CFG_POOL_UNITS, 32'd300);
                    add_ctrl(K_CFG, CFG_PHYS_BASE, 32'h1234_5640);
                end
            endcase
            for (int n = 0; n < 250; n++) begin
                if (n == 125) add_ctrl(K_HOLD, '0, '0);
                add_random_req();
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_steps.size() != 0 || i_start || expected_rsps.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_rsps.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #(64'd40_000_000);
        $display("FAIL");
        $finish;
    end

endmodule
